[hdl/fwa_pkg.sv]
package fwa_pkg;

    localparam int FLOWS        = 8;
    localparam int WINDOW       = 10;
    localparam int FLOW_W       = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int WIN_IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RUN_W        = $clog2(WINDOW + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] BASE_PORT_RESET = 16'd5000;
    localparam logic [0:0]  REG_BASE_PORT   = 1'd0;

    typedef enum logic [1:0] {
        ST_ACCEPTED      = 2'd0,
        ST_OUT_OF_WINDOW = 2'd1,
        ST_NOT_OPEN      = 2'd2
    } t_status;

    typedef logic [WINDOW-1:0] t_bitmap;

    typedef struct packed {
        logic [15:0] dest_port;
        logic [31:0] seq_number;
        logic        fin;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  flow_index;
        logic [31:0] ack_number;
        t_status     status;
        logic        closed;
    } t_out_item;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [31:0]       seq_number;
        logic              fin;
    } t_flow_item;

endpackage

[hdl/fwa_front.sv]
module fwa_front
    import fwa_pkg::*;
(
    input  logic [15:0] i_base_port,
    input  t_in_item    i_item,
    output logic        o_match,
    output t_flow_item  o_item
);

    logic [FLOW_W-1:0] flow;
    logic              hit;

    always_comb begin
        logic [15:0] want;
        flow = '0;
        hit  = 1'b0;
        for (int i = FLOWS - 1; i >= 0; i--) begin
            want = i_base_port + 16'd1 + 16'(i);
            if (want == i_item.dest_port) begin
                hit  = 1'b1;
                flow = FLOW_W'(i);
            end
        end
    end

    assign o_match           = hit;
    assign o_item.flow       = flow;
    assign o_item.seq_number = i_item.seq_number;
    assign o_item.fin        = i_item.fin;

endmodule

[hdl/fwa_queue.sv]
module fwa_queue
    import fwa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_flow_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_flow_item o_item
);

    t_flow_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;
    logic                push_ok;
    logic                pop_ok;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/fwa_back.sv]
module fwa_back
    import fwa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_flow_item i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    logic              r_open [FLOWS];
    logic [31:0]       r_head [FLOWS];
    t_bitmap           r_bmp  [FLOWS];
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              opening;
    logic              is_open;
    logic [31:0]       head;
    t_bitmap           bmp;
    logic [31:0]       offset;
    logic              in_window;
    t_bitmap           bits;
    logic [RUN_W-1:0]  run;
    logic              run_on;
    t_bitmap           n_bmp;
    logic [31:0]       n_head;
    t_out_item         n_out_item;

    assign o_pop = i_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        opening   = (i_item.seq_number == 32'd0);
        is_open   = opening || r_open[i_item.flow];
        head      = opening ? 32'd0 : r_head[i_item.flow];
        bmp       = opening ? '0 : r_bmp[i_item.flow];
        offset    = i_item.seq_number - head;
        in_window = (offset < 32'(WINDOW));
        bits      = bmp;
        if (in_window) begin
            bits = bmp | (t_bitmap'(1) << offset[WIN_IDX_W-1:0]);
        end
        run    = '0;
        run_on = 1'b1;
        for (int i = 0; i < WINDOW; i++) begin
            run_on = run_on && bits[i];
            if (run_on) begin
                run = RUN_W'(i + 1);
            end
        end
        n_bmp  = bits >> run;
        n_head = head + 32'(run);

        n_out_item.flow_index = 3'(i_item.flow);
        if (!is_open) begin
            n_out_item.ack_number = 32'd0;
            n_out_item.status     = ST_NOT_OPEN;
            n_out_item.closed     = 1'b0;
        end else begin
            n_out_item.ack_number = n_head - 32'd1;
            n_out_item.status     = in_window ? ST_ACCEPTED : ST_OUT_OF_WINDOW;
            n_out_item.closed     = i_item.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_open) begin
            r_head[i_item.flow] <= n_head;
            r_bmp[i_item.flow]  <= n_bmp;
        end
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FLOWS; i++) begin
                r_open[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && is_open) begin
                r_open[i_item.flow] <= !i_item.fin;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/per_flow_receive_window_acker.sv]
// channel   direction  handshake                  payload
// in        receive    i_in_valid / o_in_stall    i_in_item  (t_in_item)
// out       send       o_out_valid / i_out_stall  o_out_item (t_out_item)
// config    receive    APB write/read             base_port at byte address 0
//
// One segment transfer per cycle while i_out_stall is low; the back end
// updates a flow's head and bitmap flops in a same-cycle read-modify-write.
// Transfers are queued, then results registered; unmatched ports drop.
// Synchronous active-low reset closes all flows and sets base_port to 5000.
// A two-entry queue parts front and back: o_in_stall rises only when it is
// full, so the input keeps moving while one result waits on i_out_stall.
module per_flow_receive_window_acker
    import fwa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_base_port;
    logic        match;
    t_flow_item  front_item;
    logic        q_full;
    logic        q_valid;
    t_flow_item  q_item;
    logic        q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE_PORT) ? {16'd0, r_base_port} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_port <= BASE_PORT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_BASE_PORT) begin
            r_base_port <= pwdata[15:0];
        end
    end

    assign o_in_stall = q_full;

    fwa_front u_front (
        .i_base_port (r_base_port),
        .i_item      (i_in_item),
        .o_match     (match),
        .o_item      (front_item)
    );

    fwa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && match),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fwa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[hdl/fwa_checker.sv]
module fwa_checker
    import fwa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   o_out_item,
    input  logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed under stall");

    a_not_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_NOT_OPEN |->
            o_out_item.ack_number == 32'd0 && !o_out_item.closed)
        else $error("closed flow reported ack or close");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status == ST_ACCEPTED ||
            o_out_item.status == ST_OUT_OF_WINDOW || o_out_item.status == ST_NOT_OPEN)
        else $error("undefined status code");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind per_flow_receive_window_acker fwa_checker u_fwa_checker (.*);

[bench/per_flow_receive_window_acker_tb.sv]
module per_flow_receive_window_acker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwa_pkg::*;

    localparam int          LIMIT     = 100000;
    localparam int          HOLD_AT   = 200;
    localparam int          HOLD_LEN  = 400;
    localparam logic [2:0]  BASE_ADDR = {REG_BASE_PORT, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    per_flow_receive_window_acker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    t_in_item    segments_pending[$];
    t_out_item   acks_due[$];

    logic [15:0] cfg_base;
    logic        is_open [FLOWS];
    logic [31:0] head [FLOWS];
    t_bitmap     rx_map [FLOWS];

    logic        flow_live [FLOWS];
    logic [31:0] next_seq [FLOWS];

    int          cycles;
    int          segments_taken;
    int          acks_seen;
    int          errors;
    int          n_out_window;
    int          n_not_open;
    int          n_closed;
    int          base_settings;

    logic        in_fire;
    logic        hold_off;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;
    logic        stall_now;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void ack_segment(input t_in_item seg);
        int          f;
        int          run;
        logic [31:0] off;
        t_bitmap     bits;
        t_out_item   r;
        f = -1;
        for (int i = 0; i < FLOWS; i++) begin
            if (f < 0 && 16'(cfg_base + 16'd1 + 16'(i)) == seg.dest_port) begin
                f = i;
            end
        end
        if (f < 0) begin
            return;
        end
        if (seg.seq_number == 32'd0) begin
            is_open[f] = 1'b1;
            head[f]    = '0;
            rx_map[f]  = '0;
        end
        r.flow_index = 3'(f);
        r.ack_number = '0;
        r.status     = ST_ACCEPTED;
        r.closed     = 1'b0;
        if (!is_open[f]) begin
            r.status = ST_NOT_OPEN;
        end else begin
            off  = seg.seq_number - head[f];
            bits = rx_map[f];
            if (off < WINDOW) begin
                bits[off[WIN_IDX_W-1:0]] = 1'b1;
            end else begin
                r.status = ST_OUT_OF_WINDOW;
            end
            run = 0;
            while (run < WINDOW && bits[0]) begin
                bits = bits >> 1;
                run++;
            end
            rx_map[f]    = bits;
            head[f]      = head[f] + 32'(run);
            r.ack_number = head[f] - 32'd1;
            if (seg.fin) begin
                is_open[f] = 1'b0;
                r.closed   = 1'b1;
            end
        end
        acks_due.push_back(r);
    endfunction

    function automatic void flag_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 40) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    function automatic void check_ack(input t_out_item got);
        t_out_item want;
        if (acks_due.size() == 0) begin
            errors++;
            if (errors <= 40) begin
                $display("%0t: unexpected ack, expected none, got %h", $time, got);
            end
            return;
        end
        want = acks_due.pop_front();
        acks_seen++;
        if (want.status == ST_OUT_OF_WINDOW) n_out_window++;
        if (want.status == ST_NOT_OPEN) n_not_open++;
        if (want.closed) n_closed++;
        flag_field("flow_index", 32'(want.flow_index), 32'(got.flow_index));
        flag_field("ack_number", want.ack_number, got.ack_number);
        flag_field("status", 32'(want.status), 32'(got.status));
        flag_field("closed", 32'(want.closed), 32'(got.closed));
    endfunction

    function automatic logic [15:0] flow_port(input int f);
        return 16'(cfg_base + 16'd1 + 16'(f));
    endfunction

    function automatic void push_seg(input logic [15:0] port, input logic [31:0] seq,
                                     input logic fin);
        t_in_item it;
        it.dest_port  = port;
        it.seq_number = seq;
        it.fin        = fin;
        segments_pending.push_back(it);
    endfunction

    // Mostly in-window bursts per flow, lightly reordered, with duplicates,
    // stray segments, occasional drops, reopens and FINs.
    task automatic gen_traffic(input int n);
        int          made;
        int          f;
        int          a;
        int          b;
        logic        fin;
        logic [31:0] t;
        logic [31:0] blk [8];
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: push_seg(16'($urandom), $urandom, 1'($urandom));
                    1: push_seg(16'(cfg_base + 16'($urandom_range(0, 9))), $urandom,
                                1'($urandom));
                    default: push_seg(flow_port($urandom_range(0, FLOWS - 1)),
                                      $urandom_range(1, 40), 1'($urandom));
                endcase
                made++;
            end else begin
                f = $urandom_range(0, FLOWS - 1);
                if (!flow_live[f] || $urandom_range(0, 5) == 0) begin
                    push_seg(flow_port(f), 32'd0, 1'b0);
                    flow_live[f] = 1'b1;
                    next_seq[f]  = 32'd1;
                    made++;
                end
                for (int k = 0; k < 8; k++) begin
                    blk[k] = next_seq[f] + 32'(k);
                end
                repeat (3) begin
                    if ($urandom_range(0, 1) == 0) begin
                        a      = $urandom_range(0, 7);
                        b      = $urandom_range(0, 7);
                        t      = blk[a];
                        blk[a] = blk[b];
                        blk[b] = t;
                    end
                end
                for (int k = 0; k < 8; k++) begin
                    fin = (k == 7) && ($urandom_range(0, 5) == 0);
                    if ($urandom_range(0, 19) == 0) begin
                        push_seg(flow_port(f), $urandom, 1'b0);
                        made++;
                    end
                    if (fin || $urandom_range(0, 39) != 0) begin
                        push_seg(flow_port(f), blk[k], fin);
                        made++;
                    end
                    if (!fin && $urandom_range(0, 19) == 0) begin
                        push_seg(flow_port(f), blk[k], 1'b0);
                        made++;
                    end
                    if (fin) begin
                        flow_live[f] = 1'b0;
                    end
                end
                next_seq[f] = next_seq[f] + 32'd8;
            end
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BASE_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_base_readback();
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd[15:0] !== cfg_base) begin
            errors++;
            $display("%0t: base_port readback mismatch, expected %0h, got %0h",
                     $time, cfg_base, rd[15:0]);
        end
    endtask

    task automatic set_base(input logic [15:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, {16'd0, v}, rd);
        cfg_base = v;
        base_settings++;
        check_base_readback();
    endtask

    task automatic drain();
        while (segments_pending.size() != 0 || i_in_valid || acks_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles  <= cycles + 1;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            ack_segment(i_in_item);
            segments_taken <= segments_taken + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_ack(o_out_item);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (segments_pending.size() != 0) begin
                i_in_item  <= segments_pending.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(5, 60);
            end else begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = 1'($urandom);
                2: stall_now = ($urandom_range(0, 7) == 0);
                default: stall_now = ($urandom_range(0, 7) != 0);
            endcase
            i_out_stall <= hold_off || stall_now;
        end
    end

    // Hold the result side off long enough for the input to back up.
    initial begin
        wait (segments_taken >= HOLD_AT);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycles < LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_fire        = 1'b0;
        hold_off       = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        mode_left      = 0;
        stall_now      = 1'b0;
        cycles         = 0;
        segments_taken = 0;
        acks_seen      = 0;
        errors         = 0;
        n_out_window   = 0;
        n_not_open     = 0;
        n_closed       = 0;
        base_settings  = 1;
        cfg_base       = BASE_PORT_RESET;
        for (int i = 0; i < FLOWS; i++) begin
            is_open[i]   = 1'b0;
            head[i]      = '0;
            rx_map[i]    = '0;
            flow_live[i] = 1'b0;
            next_seq[i]  = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_base_readback();

        push_seg(flow_port(0), 32'd5, 1'b1);
        push_seg(16'h0000, 32'd0, 1'b0);
        push_seg(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        push_seg(cfg_base, 32'd0, 1'b0);
        push_seg(flow_port(FLOWS), 32'd0, 1'b0);
        push_seg(flow_port(0), 32'd0, 1'b0);
        push_seg(flow_port(0), 32'd2, 1'b0);
        push_seg(flow_port(0), 32'd1, 1'b0);
        push_seg(flow_port(0), 32'd12, 1'b0);
        push_seg(flow_port(0), 32'd13, 1'b0);
        push_seg(flow_port(0), 32'd1, 1'b0);
        push_seg(flow_port(0), 32'hFFFF_FFFF, 1'b0);
        for (int s = 11; s >= 3; s--) begin
            push_seg(flow_port(0), 32'(s), 1'b0);
        end
        push_seg(flow_port(0), 32'd14, 1'b1);
        push_seg(flow_port(0), 32'd5, 1'b0);
        push_seg(flow_port(FLOWS - 1), 32'd0, 1'b1);
        push_seg(flow_port(1), 32'd0, 1'b0);
        push_seg(flow_port(1), 32'd50, 1'b1);

        gen_traffic(120);
        drain();
        for (int p = 0; p < 4; p++) begin
            set_base(p == 0 ? 16'd65531 : p == 1 ? 16'd0 : p == 2 ? 16'hFFFF
                     : 16'($urandom));
            gen_traffic(120);
            drain();
        end
        repeat (10) @(posedge i_clk);

        $display("Run: %0d segment transfers, %0d acks checked over %0d base_port settings",
                 segments_taken, acks_seen, base_settings);
        $display("     %0d outside window, %0d to closed flows, %0d FIN closes, %0d errors",
                 n_out_window, n_not_open, n_closed, errors);
        if (errors == 0 && acks_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/fwa_pkg.sv
hdl/fwa_front.sv
hdl/fwa_queue.sv
hdl/fwa_back.sv
hdl/per_flow_receive_window_acker.sv
hdl/fwa_checker.sv
bench/per_flow_receive_window_acker_tb.sv
